>>> design/dsrd_pkg.sv
// Shared types, widths and codes for the dive sample record decoder.
`default_nettype none

package dsrd_pkg;

    // Sizing
    localparam int MIX_SLOTS_DEF = 8;
    localparam int DEPTH_W       = 16;
    localparam int TEMP_W        = 8;
    localparam int FLAG_W        = 8;
    localparam int GAS_W         = 3;
    localparam int SPIDX_W       = 2;
    localparam int SP_W          = 8;
    localparam int SEC_W         = 20;
    localparam int VALUE_W       = 30;
    localparam int KIND_W        = 3;
    localparam int PREV_W        = 4;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 32;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int NUM_SP        = 4;

    // Sample timing
    localparam int SAMPLE_INTERVAL = 10;
    localparam int MS_PER_S        = 1000;

    // Flag byte layout
    localparam int CCR_BIT = 7;
    localparam int SP_LSB  = 5;
    localparam int GAS_LSB = 2;

    // Marker for no previous gas
    localparam logic [PREV_W-1:0] NO_MIX = 4'd8;

    // Result kinds
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_TIME  = 3'd0;
    localparam t_kind KIND_DEPTH = 3'd1;
    localparam t_kind KIND_TEMP  = 3'd2;
    localparam t_kind KIND_GAS   = 3'd3;
    localparam t_kind KIND_SP    = 3'd4;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_ZERO  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_ONE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_TWO   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_THREE = 3'd3;

    // Request to the gas table unit
    typedef struct packed {
        logic             clear;
        logic             start;
        logic [GAS_W-1:0] gas;
    } t_mix_req;

endpackage

`default_nettype wire

>>> design/dsrd_mix_table.sv
// First-seen gas table with a one-entry-per-cycle search and append.
`default_nettype none

module dsrd_mix_table #(
    parameter int MIX_SLOTS = dsrd_pkg::MIX_SLOTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  dsrd_pkg::t_mix_req                i_req,
    output logic                              o_done,
    output logic [$clog2(MIX_SLOTS+1)-1:0]    o_index
);
    import dsrd_pkg::*;

    localparam int CW = $clog2(MIX_SLOTS + 1);
    localparam int IW = (MIX_SLOTS > 1) ? $clog2(MIX_SLOTS) : 1;
    localparam logic [CW-1:0] SLOTS = CW'(MIX_SLOTS);

    logic [GAS_W-1:0] r_table [MIX_SLOTS];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_idx;
    logic             r_busy;
    logic [GAS_W-1:0] r_gas;
    logic             r_done;
    logic [CW-1:0]    r_index;

    logic             w_in_range;
    logic [GAS_W-1:0] w_entry;
    logic             w_hit;

    // Shared compare: one table entry against the searched id
    always_comb begin
        w_in_range = (r_idx < r_count);
        w_entry    = w_in_range ? r_table[r_idx[IW-1:0]] : '0;
        w_hit      = w_in_range && (w_entry == r_gas);
    end

    // Walk the table; append on a miss while room is left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_idx   <= '0;
            for (int i = 0; i < MIX_SLOTS; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_gas  <= i_req.gas;
            end else if (r_busy) begin
                if (w_hit) begin
                    r_index <= r_idx;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end else if (!w_in_range) begin
                    if (r_count < SLOTS) begin
                        r_table[r_count[IW-1:0]] <= r_gas;
                        r_count                  <= r_count + 1'b1;
                        r_index                  <= r_count;
                    end else begin
                        r_index <= SLOTS;
                    end
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_index = r_index;

endmodule

`default_nettype wire

>>> design/dive_sample_record_decoder_unit.sv
// Top level of the dive sample record decoder: sequencer, time, setpoints, result register.
//
//  channel    | dir | handshake                    | contents
//  s_axis     | in  | s_axis_tvalid/s_axis_tready  | tdata depth, temperature, flags; tuser start
//  m_axis     | out | m_axis_tvalid/m_axis_tready  | tdata value; tuser kind; tlast
//  cfg        | in  | i_cfg_we                     | i_cfg_addr setpoint index, i_cfg_data byte
//
// With the gas id unchanged a sample is the transfer, then the time, depth and temperature
// result loads, plus a setpoint result load in CCR mode. A gas change adds the shared search
// unit: one compare per table entry, an append or give-up on a miss and a handoff of the
// index, then the gas result load. Input is taken only while the sequencer is idle; the last
// result may still sit in the output register then. A stalled result holds the sequencer at
// its next result load. Reset is synchronous.
`default_nettype none

module dive_sample_record_decoder_unit #(
    parameter int MIX_SLOTS = dsrd_pkg::MIX_SLOTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // tdata: depth_raw[15:0], temperature_raw[23:16], flag_byte[31:24]
    input  wire  [dsrd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: dive_start[0]
    input  wire  [0:0]                        s_axis_tuser,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: value[29:0], zero[31:30]
    output logic [dsrd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: kind[2:0]
    output logic [dsrd_pkg::KIND_W-1:0]       m_axis_tuser,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    input  wire                               i_cfg_we,
    input  wire  [dsrd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire  [dsrd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dsrd_pkg::*;

    localparam int CW = $clog2(MIX_SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TIME  = 3'd1;
    localparam logic [2:0] S_DEPTH = 3'd2;
    localparam logic [2:0] S_TEMP  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_GAS   = 3'd5;
    localparam logic [2:0] S_SP    = 3'd6;

    logic [2:0]         r_state,     n_state;
    logic [SEC_W-1:0]   r_sec,       n_sec;
    logic [PREV_W-1:0]  r_prev,      n_prev;
    logic               r_out_valid, n_out_valid;
    t_kind              r_kind,      n_kind;
    logic [VALUE_W-1:0] r_value,     n_value;
    logic               r_last,      n_last;
    logic [CW-1:0]      r_gas_idx,   n_gas_idx;

    logic [SP_W-1:0]    r_setpoint [NUM_SP];
    logic [DEPTH_W-1:0] r_depth;
    logic [TEMP_W-1:0]  r_temp;
    logic               r_ccr;
    logic [SPIDX_W-1:0] r_sp;
    logic [GAS_W-1:0]   r_gas;

    logic               w_accept;
    logic               w_out_free;
    logic               w_gas_new;
    logic [VALUE_W-1:0] w_time_ms;
    t_mix_req           w_req;
    logic               w_mix_done;
    logic [CW-1:0]      w_mix_index;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_gas_new  = ({1'b0, r_gas} != r_prev);
    assign w_time_ms  = VALUE_W'(r_sec) * VALUE_W'(MS_PER_S);

    // Gas table search unit
    dsrd_mix_table #(
        .MIX_SLOTS (MIX_SLOTS)
    ) u_mix_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_mix_done),
        .o_index (w_mix_index)
    );

    // Sequence the results of one sample
    always_comb begin
        n_state     = r_state;
        n_sec       = r_sec;
        n_prev      = r_prev;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_kind      = r_kind;
        n_value     = r_value;
        n_last      = r_last;
        n_gas_idx   = r_gas_idx;
        w_req       = '0;
        w_req.gas   = r_gas;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser[0]) begin
                        n_sec       = SEC_W'(SAMPLE_INTERVAL);
                        n_prev      = NO_MIX;
                        w_req.clear = 1'b1;
                    end else begin
                        n_sec = r_sec + SEC_W'(SAMPLE_INTERVAL);
                    end
                    n_state = S_TIME;
                end
            end
            S_TIME: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TIME;
                    n_value     = w_time_ms;
                    n_last      = 1'b0;
                    n_state     = S_DEPTH;
                end
            end
            S_DEPTH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DEPTH;
                    n_value     = VALUE_W'(r_depth);
                    n_last      = 1'b0;
                    n_state     = S_TEMP;
                end
            end
            S_TEMP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TEMP;
                    n_value     = VALUE_W'(r_temp);
                    n_last      = !w_gas_new && !r_ccr;
                    if (w_gas_new) begin
                        w_req.start = 1'b1;
                        n_state     = S_SCAN;
                    end else if (r_ccr) begin
                        n_state = S_SP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (w_mix_done) begin
                    n_gas_idx = w_mix_index;
                    n_state   = S_GAS;
                end
            end
            S_GAS: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_GAS;
                    n_value     = VALUE_W'(r_gas_idx);
                    n_last      = !r_ccr;
                    n_prev      = {1'b0, r_gas};
                    n_state     = r_ccr ? S_SP : S_IDLE;
                end
            end
            S_SP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_SP;
                    n_value     = VALUE_W'(r_setpoint[r_sp]);
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sec       <= '0;
            r_prev      <= NO_MIX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sec       <= n_sec;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload and search result
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_value   <= n_value;
        r_last    <= n_last;
        r_gas_idx <= n_gas_idx;
    end

    // Capture sample fields on transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_depth <= s_axis_tdata[DEPTH_W-1:0];
            r_temp  <= s_axis_tdata[DEPTH_W +: TEMP_W];
            r_ccr   <= s_axis_tdata[DEPTH_W + TEMP_W + CCR_BIT];
            r_sp    <= s_axis_tdata[DEPTH_W + TEMP_W + SP_LSB +: SPIDX_W];
            r_gas   <= s_axis_tdata[DEPTH_W + TEMP_W + GAS_LSB +: GAS_W];
        end
    end

    // Setpoint registers; other indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SP; i++) begin
                r_setpoint[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SETPOINT_ZERO:  r_setpoint[0] <= i_cfg_data;
                REG_SETPOINT_ONE:   r_setpoint[1] <= i_cfg_data;
                REG_SETPOINT_TWO:   r_setpoint[2] <= i_cfg_data;
                REG_SETPOINT_THREE: r_setpoint[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Drive ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_value);
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

    // A setpoint result always closes its sample
    a_sp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_SP)) |-> m_axis_tlast)
        else $error("setpoint result without tlast");

    // The time result never closes a sample
    a_time_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_TIME)) |-> !m_axis_tlast)
        else $error("time result carries tlast");

    // The gas index never exceeds the slot count
    a_gas_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_GAS))
            |-> (m_axis_tdata <= OUT_TDATA_W'(MIX_SLOTS)))
        else $error("gas index out of range");

    // The search unit reports only while the sequencer waits for it
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mix_done |-> (r_state == S_SCAN))
        else $error("search done outside scan");

endmodule

`default_nettype wire

>>> sim/dive_sample_record_decoder_unit_tb.sv
// Self-checking testbench for the dive sample record decoder: directed and random runs.
`timescale 1ns / 1ps

module dive_sample_record_decoder_unit_tb;
    import dsrd_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 4 * (MIX_SLOTS_DEF + 8);

    // One dive log sample; hold marks a sample that waits until all results are back
    typedef struct packed {
        logic              hold;
        logic              start;
        logic [FLAG_W-1:0] flags;
        logic [TEMP_W-1:0] temp;
        logic [DEPTH_W-1:0] depth;
    } t_sample;

    // One decoded record as it should leave the block
    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_record;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    t_sample     sample_backlog[$];
    t_record     expected_records[$];
    t_sample     sample_on_bus;
    int          sender_idle_pct = 0;
    int          sink_stall_pct  = 0;
    int          mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    // Decoder state as the block should hold it
    logic [SP_W-1:0]   setpoint_regs [NUM_SP];
    logic [SEC_W-1:0]  elapsed_s = '0;
    logic [GAS_W-1:0]  mix_tab [MIX_SLOTS_DEF];
    logic [PREV_W-1:0] mix_cnt  = '0;
    logic [PREV_W-1:0] prev_mix = NO_MIX;

    initial begin
        foreach (setpoint_regs[i]) setpoint_regs[i] = '0;
        foreach (mix_tab[i]) mix_tab[i] = '0;
    end

    dive_sample_record_decoder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_sample make_sample(input logic start, input logic [DEPTH_W-1:0] depth,
                                            input logic [TEMP_W-1:0] temp, input logic ccr,
                                            input logic [SPIDX_W-1:0] spi,
                                            input logic [GAS_W-1:0] gas, input logic [1:0] spare);
        return {1'b0, start, ccr, spi, gas, spare, temp, depth};
    endfunction

    // Advance the dive state by one sample and queue the records it yields
    task automatic decode_sample(input t_sample smp);
        t_record            recs [5];
        int                 n;
        logic [GAS_W-1:0]   gas;
        logic [SPIDX_W-1:0] spi;
        logic [PREV_W-1:0]  idx;
        logic [31:0]        ms;
        gas = smp.flags[GAS_LSB +: GAS_W];
        spi = smp.flags[SP_LSB +: SPIDX_W];
        n   = 0;
        if (smp.start) begin
            elapsed_s = '0;
            mix_cnt   = '0;
            prev_mix  = NO_MIX;
            foreach (mix_tab[i]) mix_tab[i] = '0;
        end
        // Elapsed seconds wrap at the counter width
        elapsed_s = elapsed_s + SEC_W'(SAMPLE_INTERVAL);
        ms = 32'(elapsed_s) * MS_PER_S;
        recs[0] = {KIND_TIME, ms[VALUE_W-1:0], 1'b0};
        recs[1] = {KIND_DEPTH, VALUE_W'(smp.depth), 1'b0};
        recs[2] = {KIND_TEMP, VALUE_W'(smp.temp), 1'b0};
        n = 3;
        // Gas change: look up first-seen slot, append when new
        if ({1'b0, gas} != prev_mix) begin
            idx = mix_cnt;
            for (int i = MIX_SLOTS_DEF - 1; i >= 0; i--) begin
                if (i < mix_cnt && mix_tab[i] == gas) idx = PREV_W'(i);
            end
            if (idx == mix_cnt) begin
                mix_tab[mix_cnt[GAS_W-1:0]] = gas;
                mix_cnt = mix_cnt + 1'b1;
            end
            recs[n] = {KIND_GAS, VALUE_W'(idx), 1'b0};
            n = n + 1;
            prev_mix = {1'b0, gas};
        end
        if (smp.flags[CCR_BIT]) begin
            recs[n] = {KIND_SP, VALUE_W'(setpoint_regs[spi]), 1'b0};
            n = n + 1;
        end
        recs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_records.push_back(recs[i]);
    endtask

    // Write all four setpoints, then one write to an unused index
    task automatic apply_setpoints(input logic [SP_W-1:0] sp0, input logic [SP_W-1:0] sp1,
                                   input logic [SP_W-1:0] sp2, input logic [SP_W-1:0] sp3);
        logic [CFG_ADDR_W-1:0] addrs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        addrs = '{REG_SETPOINT_ZERO, REG_SETPOINT_ONE, REG_SETPOINT_TWO, REG_SETPOINT_THREE,
                  CFG_ADDR_W'($urandom_range(NUM_SP, (1 << CFG_ADDR_W) - 1))};
        vals  = '{sp0, sp1, sp2, sp3, CFG_DATA_W'($urandom)};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= addrs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            if (addrs[i] < NUM_SP) setpoint_regs[addrs[i][SPIDX_W-1:0]] = vals[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // Block until the bus is empty and every expected record has come back
    task automatic wait_all_results();
        while (sample_backlog.size() != 0 || s_axis_tvalid || expected_records.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed dives with random content, the rest raw noise
    task automatic queue_dive_samples(input int count);
        t_sample          smp;
        int               dive_left;
        logic [GAS_W-1:0] gas_now;
        dive_left = 0;
        gas_now   = '0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 10) begin
                smp.start = 1'($urandom);
                smp.flags = FLAG_W'($urandom);
                smp.temp  = TEMP_W'($urandom);
                smp.depth = DEPTH_W'($urandom);
            end else begin
                if ($urandom_range(0, 99) < 35) gas_now = GAS_W'($urandom);
                smp = make_sample(dive_left == 0, DEPTH_W'($urandom), TEMP_W'($urandom),
                                  1'($urandom), SPIDX_W'($urandom), gas_now, 2'($urandom));
                if (dive_left == 0) dive_left = $urandom_range(3, 30);
                dive_left--;
            end
            smp.hold = (k == count / 2) || ($urandom_range(0, 99) < 3);
            sample_backlog.push_back(smp);
        end
    endtask

    // Sample driver: predict on each transfer, then present the next sample or idle
    always @(posedge i_clk) begin : drive_samples
        t_sample nxt;
        logic    send;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) decode_sample(sample_on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                send = 1'b0;
                if (sample_backlog.size() != 0) begin
                    nxt  = sample_backlog[0];
                    send = ($urandom_range(0, 99) >= sender_idle_pct) &&
                           !(nxt.hold && expected_records.size() != 0);
                end
                if (send) begin
                    nxt = sample_backlog.pop_front();
                    sample_on_bus  = nxt;
                    s_axis_tdata  <= {nxt.flags, nxt.temp, nxt.depth};
                    s_axis_tuser  <= nxt.start;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tdata  <= IN_TDATA_W'($urandom);
                    s_axis_tuser  <= 1'($urandom);
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Record monitor: compare each transfer with the oldest expected record
    always @(posedge i_clk) begin : check_records
        t_record want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_records.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected record: kind %0d tdata %0d last %0b", $time,
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_records.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tlast !== want.last ||
                        m_axis_tdata !== {{(OUT_TDATA_W - VALUE_W){1'b0}}, want.value}) begin
                        mismatch_count++;
                        $display("%0t: expected kind %0d value %0d last %0b, got kind %0d %s",
                                 $time, want.kind, want.value, want.last, m_axis_tuser,
                                 $sformatf("tdata %0d last %0b", m_axis_tdata, m_axis_tlast));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dive_sample_record_decoder_unit verification failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Setpoints still at reset; first gas differs from the no-gas marker
        sample_backlog.push_back(make_sample(1'b0, 16'h0000, 8'h00, 1'b1, 2'd0, 3'd0, 2'd0));
        sample_backlog.push_back(make_sample(1'b0, 16'hFFFF, 8'hFF, 1'b1, 2'd3, 3'd0, 2'd3));
        wait_all_results();
        apply_setpoints(8'h00, 8'hFF, 8'hA5, 8'h5A);

        // Fill the gas table with every id, then revisit, restart and hit extremes
        for (int g = 0; g < 8; g++)
            sample_backlog.push_back(make_sample(g == 0, DEPTH_W'(g * 9000), TEMP_W'(g * 36),
                                                 1'(g % 2), SPIDX_W'(g % 4), GAS_W'(g),
                                                 2'(g % 4)));
        sample_backlog.push_back(make_sample(1'b0, 16'd35, 8'd12, 1'b0, 2'd0, 3'd7, 2'd3));
        sample_backlog.push_back(make_sample(1'b0, 16'd400, 8'd11, 1'b1, 2'd1, 3'd3, 2'd0));
        sample_backlog.push_back(make_sample(1'b0, 16'd410, 8'd10, 1'b1, 2'd2, 3'd0, 2'd1));
        sample_backlog.push_back(make_sample(1'b0, 16'd420, 8'd10, 1'b1, 2'd3, 3'd0, 2'd2));
        sample_backlog.push_back(make_sample(1'b1, 16'd10, 8'd25, 1'b0, 2'd0, 3'd5, 2'd0));
        sample_backlog.push_back(make_sample(1'b0, 16'd20, 8'd24, 1'b1, 2'd0, 3'd2, 2'd0));
        sample_backlog.push_back(make_sample(1'b1, 16'd30, 8'd23, 1'b0, 2'd0, 3'd2, 2'd3));
        sample_backlog.push_back(make_sample(1'b0, 16'hFFFF, 8'hFF, 1'b1, 2'd3, 3'd7, 2'd3));
        sample_backlog.push_back(make_sample(1'b0, 16'h0000, 8'h00, 1'b0, 2'd0, 3'd0, 2'd0));
        sample_backlog.push_back(make_sample(1'b1, 16'h8000, 8'h80, 1'b1, 2'd1, 3'd4, 2'd0));

        // Random dives under each idling mode, new setpoints per mode
        for (int p = 0; p < 4; p++) begin
            wait_all_results();
            case (p)
                0: apply_setpoints(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                1: apply_setpoints(8'h00, 8'h00, 8'h00, 8'h00);
                default: apply_setpoints(SP_W'($urandom), SP_W'($urandom), SP_W'($urandom),
                                         SP_W'($urandom));
            endcase
            case (p)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin sender_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            queue_dive_samples(75);
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_records.size() == 0)
            $display("dive_sample_record_decoder_unit verification clean");
        else
            $display("dive_sample_record_decoder_unit verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/dsrd_pkg.sv
design/dsrd_mix_table.sv
design/dive_sample_record_decoder_unit.sv
sim/dive_sample_record_decoder_unit_tb.sv
